// ===== src/copsp_pkg.sv =====
// ----------------------------------------------------------------------------
// CoAP option stream parser package
// Shared types and constants for the option parser and its result queue.
// ----------------------------------------------------------------------------
package copsp_pkg;

	localparam int DATA_W   = 8;
	localparam int TARGET_W = 16;
	localparam int LEN_W    = 17;
	localparam int INT_W    = 32;
	localparam int OCC_W    = 8;

	// Result kinds.
	localparam logic [1:0] KIND_VALUE   = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	// Summary status codes.
	localparam logic [1:0] ST_FOUND  = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_TRUNC  = 2'd2;

	localparam logic [7:0]       PAYLOAD_MARKER = 8'hFF;
	localparam logic [3:0]       NIB_EXT1       = 4'd13;
	localparam logic [3:0]       NIB_EXT2       = 4'd14;
	localparam logic [3:0]       NIB_RSVD       = 4'd15;
	localparam logic [LEN_W-1:0] EXT1_BIAS      = 17'd13;
	localparam logic [LEN_W-1:0] EXT2_BIAS      = 17'd269;
	localparam logic [4:0]       FIXED_HDR_SKIP = 5'd3;
	localparam logic [OCC_W-1:0] OCC_MAX        = 8'hFF;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [1:0]          kind;
		logic [DATA_W-1:0]   value_byte;
		logic [LEN_W-1:0]    value_index;
		logic [LEN_W-1:0]    value_length;
		logic                value_last;
		logic [INT_W-1:0]    int_value;
		logic [OCC_W-1:0]    occurrence;
		logic [1:0]          status;
	} copsp_result_t;

endpackage

// ===== src/copsp_parser.sv =====
// ----------------------------------------------------------------------------
// CoAP option parser core
// Per-byte state update of the option walk; produces up to two results.
// ----------------------------------------------------------------------------
module copsp_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [copsp_pkg::TARGET_W-1:0]   target_option,
	input  logic                             step,
	input  logic [copsp_pkg::DATA_W-1:0]     data_byte,
	input  logic                             end_of_message,
	output logic                             res0_valid,
	output copsp_pkg::copsp_result_t         res0,
	output logic                             res1_valid,
	output copsp_pkg::copsp_result_t         res1
);
	import copsp_pkg::*;

	typedef enum logic [3:0] {
		PH_BYTE0, PH_SKIP, PH_OPT, PH_DEXT1, PH_DEXT2A, PH_DEXT2B,
		PH_LEXT1, PH_LEXT2A, PH_LEXT2B, PH_VALUE, PH_DONE
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [4:0]         skip_q, skip_n;
	logic [LEN_W-1:0]   opt_q, opt_n;
	logic [3:0]         nib_q, nib_n;
	logic [7:0]         hold_q, hold_n;
	logic [LEN_W-1:0]   rem_q, rem_n;
	logic [LEN_W-1:0]   total_q, total_n;
	logic               match_q, match_n;
	logic [INT_W-1:0]   accum_q, accum_n;
	logic [OCC_W-1:0]   found_q, found_n;

	logic               do_delta, do_len;
	logic [LEN_W-1:0]   delta, len;
	logic [LEN_W:0]     num;
	logic               trunc;

	always_comb begin
		phase_n    = phase_q;
		skip_n     = skip_q;
		opt_n      = opt_q;
		nib_n      = nib_q;
		hold_n     = hold_q;
		rem_n      = rem_q;
		total_n    = total_q;
		match_n    = match_q;
		accum_n    = accum_q;
		found_n    = found_q;
		do_delta   = 1'b0;
		do_len     = 1'b0;
		delta      = '0;
		len        = '0;
		num        = '0;
		trunc      = 1'b0;
		res0_valid = 1'b0;
		res0       = '0;
		res1_valid = 1'b0;
		res1       = '0;

		unique case (phase_q)
			PH_BYTE0: begin
				skip_n  = FIXED_HDR_SKIP + 5'(data_byte[3:0]);
				phase_n = PH_SKIP;
			end
			PH_SKIP: begin
				if (skip_q != '0) skip_n = skip_q - 5'd1;
				if (skip_n == '0) phase_n = PH_OPT;
			end
			PH_OPT: begin
				if (data_byte == PAYLOAD_MARKER || data_byte[7:4] == NIB_RSVD) begin
					phase_n = PH_DONE;
				end else begin
					nib_n = data_byte[3:0];
					if (data_byte[7:4] == NIB_EXT1) begin
						phase_n = PH_DEXT1;
					end else if (data_byte[7:4] == NIB_EXT2) begin
						phase_n = PH_DEXT2A;
					end else begin
						do_delta = 1'b1;
						delta    = LEN_W'(data_byte[7:4]);
					end
				end
			end
			PH_DEXT1: begin
				do_delta = 1'b1;
				delta    = LEN_W'(data_byte) + EXT1_BIAS;
			end
			PH_DEXT2A: begin
				hold_n  = data_byte;
				phase_n = PH_DEXT2B;
			end
			PH_DEXT2B: begin
				do_delta = 1'b1;
				delta    = LEN_W'({hold_q, data_byte}) + EXT2_BIAS;
			end
			PH_LEXT1: begin
				do_len = 1'b1;
				len    = LEN_W'(data_byte) + EXT1_BIAS;
			end
			PH_LEXT2A: begin
				hold_n  = data_byte;
				phase_n = PH_LEXT2B;
			end
			PH_LEXT2B: begin
				do_len = 1'b1;
				len    = LEN_W'({hold_q, data_byte}) + EXT2_BIAS;
			end
			PH_VALUE: begin
				if (rem_q != '0) rem_n = rem_q - 17'd1;
				if (match_q) begin
					accum_n                 = {accum_q[INT_W-9:0], data_byte};
					res0_valid              = 1'b1;
					res0.kind               = KIND_VALUE;
					res0.value_byte         = data_byte;
					res0.value_index        = total_q - rem_n - 17'd1;
					res0.value_length       = total_q;
					res0.value_last         = (rem_n == '0);
					res0.int_value          = accum_n;
					res0.occurrence         = found_q;
				end
				if (rem_n == '0) phase_n = PH_OPT;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// Option delta: advance the running number (or stop past the target), then look at the length nibble.
		if (do_delta) begin
			num = {1'b0, opt_q} + {1'b0, delta};
			if (num > (LEN_W+1)'(target_option)) begin
				phase_n = PH_DONE;
			end else begin
				opt_n = num[LEN_W-1:0];
				if (nib_n == NIB_RSVD) begin
					phase_n = PH_DONE;
				end else if (nib_n == NIB_EXT1) begin
					phase_n = PH_LEXT1;
				end else if (nib_n == NIB_EXT2) begin
					phase_n = PH_LEXT2A;
				end else begin
					do_len = 1'b1;
					len    = LEN_W'(nib_n);
				end
			end
		end

		if (do_len) begin
			match_n = (opt_n == LEN_W'(target_option));
			total_n = len;
			rem_n   = len;
			if (match_n) begin
				if (found_q != OCC_MAX) found_n = found_q + 8'd1;
				accum_n = '0;
				if (len == '0) begin
					res0_valid      = 1'b1;
					res0.kind       = KIND_EMPTY;
					res0.occurrence = found_n;
				end
			end
			phase_n = (len == '0) ? PH_OPT : PH_VALUE;
		end

		if (end_of_message) begin
			trunc           = phase_n inside {PH_DEXT1, PH_DEXT2A, PH_DEXT2B, PH_LEXT1,
				PH_LEXT2A, PH_LEXT2B, PH_VALUE};
			res1_valid      = 1'b1;
			res1.kind       = KIND_SUMMARY;
			res1.occurrence = found_n;
			if (trunc) res1.status = ST_TRUNC;
			else if (found_n != '0) res1.status = ST_FOUND;
			else res1.status = ST_ABSENT;
			phase_n = PH_BYTE0;
			skip_n  = '0;
			opt_n   = '0;
			nib_n   = '0;
			hold_n  = '0;
			rem_n   = '0;
			total_n = '0;
			match_n = 1'b0;
			accum_n = '0;
			found_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BYTE0;
			skip_q  <= '0;
			opt_q   <= '0;
			nib_q   <= '0;
			hold_q  <= '0;
			rem_q   <= '0;
			total_q <= '0;
			match_q <= 1'b0;
			accum_q <= '0;
			found_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			opt_q   <= opt_n;
			nib_q   <= nib_n;
			hold_q  <= hold_n;
			rem_q   <= rem_n;
			total_q <= total_n;
			match_q <= match_n;
			accum_q <= accum_n;
			found_q <= found_n;
		end
	end

	a_eom_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_message |=> phase_q == PH_BYTE0 && found_q == '0)
		else $error("parser did not restart after end of message");

	a_value_pending: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VALUE |-> rem_q != '0 && rem_q <= total_q)
		else $error("value phase with no bytes left");

	a_skip_pending: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != '0)
		else $error("skip phase with empty skip count");

endmodule

// ===== src/copsp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// CoAP option parser result queue
// Small queue that takes up to two results per cycle while it has room for two and hands out one.
// ----------------------------------------------------------------------------
module copsp_result_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_cnt,
	input  copsp_pkg::copsp_result_t   push_a,
	input  copsp_pkg::copsp_result_t   push_b,
	output logic                       room_for_two,
	output logic                       out_valid,
	input  logic                       out_ready,
	output copsp_pkg::copsp_result_t   out_data
);
	import copsp_pkg::*;

	copsp_result_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_b;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;

	assign out_valid    = (count_q != '0);
	assign out_data     = mem_q[rd_ptr_q];
	assign pop          = out_valid && out_ready;
	assign room_for_two = (count_q <= QCNT_W'(QDEPTH - 2));
	assign wr_ptr_b     = wr_ptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_ptr_q] <= push_a;
		if (push_cnt == 2'd2) mem_q[wr_ptr_b] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push_cnt) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt != 2'd0 |-> room_for_two)
		else $error("results pushed without room for two");

endmodule

// ===== src/coap_option_stream_parser.sv =====
// ----------------------------------------------------------------------------
// CoAP option stream parser
// Walks a CoAP message a byte at a time and reports the target option values.
// ----------------------------------------------------------------------------
// The block takes one message byte per transaction and can accept a byte every
// cycle while the result queue has room for two results. An accepted byte is
// held in an input register, the option walk is decoded from it, and its results
// (at most two: a value byte or empty match, then the end-of-message summary)
// enter a four-entry result queue that offers them downstream. The input
// keeps flowing while the queue has room for two results; a downstream that
// stalls fills the queue and then holds the input off. target_option may be
// written only while no message is in flight.
module coap_option_stream_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,      // target_option
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic         s_axis_tlast,   // end_of_message
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// value_byte[7:0], value_index[24:8], value_length[41:25], int_value[73:42],
	// occurrence[81:74], status[83:82], zero[87:84]
	output logic [87:0]  m_axis_tdata,
	output logic [1:0]   m_axis_tuser,   // kind
	output logic         m_axis_tlast    // value_last
);
	import copsp_pkg::*;

	logic [TARGET_W-1:0]  target_q;
	logic                 valid_s1;
	logic [DATA_W-1:0]    byte_s1;
	logic                 eom_s1;
	logic                 room_for_two;
	logic                 process;
	logic                 res0_valid, res1_valid;
	copsp_result_t        res0, res1, push_a, out_data;
	logic [1:0]           push_cnt;

	assign process       = valid_s1 && room_for_two;
	assign s_axis_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) target_q <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) valid_s1 <= 1'b1;
			else if (process) valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eom_s1  <= s_axis_tlast;
		end
	end

	copsp_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.target_option  (target_q),
		.step           (process),
		.data_byte      (byte_s1),
		.end_of_message (eom_s1),
		.res0_valid     (res0_valid),
		.res0           (res0),
		.res1_valid     (res1_valid),
		.res1           (res1)
	);

	// The first valid result always goes into the first queue slot.
	assign push_a   = res0_valid ? res0 : res1;
	assign push_cnt = process ? (2'(res0_valid) + 2'(res1_valid)) : 2'd0;

	copsp_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_cnt     (push_cnt),
		.push_a       (push_a),
		.push_b       (res1),
		.room_for_two (room_for_two),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (out_data)
	);

	assign m_axis_tdata = {4'b0000, out_data.status, out_data.occurrence, out_data.int_value,
		out_data.value_length, out_data.value_index, out_data.value_byte};
	assign m_axis_tuser = out_data.kind;
	assign m_axis_tlast = out_data.value_last;

endmodule
